@@ sv/rbd_pkg.sv @@
// ----------------------------------------------------------------------------
// rbd_pkg: shared constants, types and tables
// Widths, CORDIC step count and the arctangent table in Q16 degrees.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned CORDIC_STEPS   = 20;
  localparam int unsigned VEC_SHIFT      = 16;
  localparam int unsigned ANG_FRAC       = 16;
  localparam int unsigned ZW             = 25;  // signed Q16 degree accumulator
  localparam int unsigned TURN_W         = 10;
  localparam int unsigned DIST_W         = 13;
  localparam int unsigned MID_W          = 12;

  // classification of one atan2 argument pair
  typedef struct packed {
    logic zero;   // both components zero
    logic yz;     // |a| == 0
    logic xz;     // |b| == 0
    logic eq;     // |a| == |b|
    logic aneg;   // a < 0
    logic bneg;   // b < 0
  } ang_flag_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(2949120);
      1:  r = ZW'(1740967);
      2:  r = ZW'(919879);
      3:  r = ZW'(466945);
      4:  r = ZW'(234379);
      5:  r = ZW'(117304);
      6:  r = ZW'(58666);
      7:  r = ZW'(29335);
      8:  r = ZW'(14668);
      9:  r = ZW'(7334);
      10: r = ZW'(3667);
      11: r = ZW'(1833);
      12: r = ZW'(917);
      13: r = ZW'(458);
      14: r = ZW'(229);
      15: r = ZW'(115);
      16: r = ZW'(57);
      17: r = ZW'(29);
      18: r = ZW'(14);
      19: r = ZW'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/rbd_prep.sv @@
// ----------------------------------------------------------------------------
// rbd_prep: front stages
// Stage A: middle point and differences. Stage B: folding, flags, squares.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_prep import rbd_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned CW  = COORD_BITS,
  localparam int unsigned DW  = CW + 1,
  localparam int unsigned XW  = CW + VEC_SHIFT + 3,
  localparam int unsigned SQW = 2 * CW + 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  vld_i,
  input  wire logic [CW-1:0]         fx_i,
  input  wire logic [CW-1:0]         fy_i,
  input  wire logic [CW-1:0]         bx_i,
  input  wire logic [CW-1:0]         by_i,
  input  wire logic [CW-1:0]         tx_i,
  input  wire logic [CW-1:0]         ty_i,
  output logic                       vld_o,
  output logic signed [XW-1:0]       x1_o,
  output logic signed [XW-1:0]       y1_o,
  output logic signed [XW-1:0]       x2_o,
  output logic signed [XW-1:0]       y2_o,
  output ang_flag_t                  f1_o,
  output ang_flag_t                  f2_o,
  output logic [SQW-1:0]             sq_o,
  output logic [CW-1:0]              mx_o,
  output logic [CW-1:0]              my_o
);

  logic                 vld_a_q;
  logic signed [DW-1:0] a1_q, b1_q, a2_q, b2_q;
  logic [CW-1:0]        mxa_q, mya_q;
  logic [CW-1:0]        mx_d, my_d;
  logic signed [DW-1:0] a2_d, b2_d;

  always_comb begin
    mx_d = CW'(({1'b0, fx_i} + {1'b0, bx_i}) >> 1);
    my_d = CW'(({1'b0, fy_i} + {1'b0, by_i}) >> 1);
    a2_d = $signed({1'b0, mx_d}) - $signed({1'b0, tx_i});
    b2_d = $signed({1'b0, my_d}) - $signed({1'b0, ty_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= $signed({1'b0, fx_i}) - $signed({1'b0, bx_i});
      b1_q  <= $signed({1'b0, fy_i}) - $signed({1'b0, by_i});
      a2_q  <= a2_d;
      b2_q  <= b2_d;
      mxa_q <= mx_d;
      mya_q <= my_d;
    end
  end

  // stage B
  logic [CW-1:0]         aa1, bb1, aa2, bb2;
  logic signed [SQW-1:0] a2e, b2e;
  ang_flag_t             f1_d, f2_d;

  always_comb begin
    aa1 = CW'(a1_q < 0 ? -a1_q : a1_q);
    bb1 = CW'(b1_q < 0 ? -b1_q : b1_q);
    aa2 = CW'(a2_q < 0 ? -a2_q : a2_q);
    bb2 = CW'(b2_q < 0 ? -b2_q : b2_q);
    a2e = SQW'(a2_q);
    b2e = SQW'(b2_q);
    f1_d.zero = (aa1 == '0) && (bb1 == '0);
    f1_d.yz   = (aa1 == '0);
    f1_d.xz   = (bb1 == '0);
    f1_d.eq   = (aa1 == bb1);
    f1_d.aneg = a1_q[DW-1];
    f1_d.bneg = b1_q[DW-1];
    f2_d.zero = (aa2 == '0) && (bb2 == '0);
    f2_d.yz   = (aa2 == '0);
    f2_d.xz   = (bb2 == '0);
    f2_d.eq   = (aa2 == bb2);
    f2_d.aneg = a2_q[DW-1];
    f2_d.bneg = b2_q[DW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_o <= $signed(XW'({bb1, {VEC_SHIFT{1'b0}}}));
      y1_o <= $signed(XW'({aa1, {VEC_SHIFT{1'b0}}}));
      x2_o <= $signed(XW'({bb2, {VEC_SHIFT{1'b0}}}));
      y2_o <= $signed(XW'({aa2, {VEC_SHIFT{1'b0}}}));
      f1_o <= f1_d;
      f2_o <= f2_d;
      sq_o <= SQW'($unsigned(a2e * a2e)) + SQW'($unsigned(b2e * b2e));
      mx_o <= mxa_q;
      my_o <= mya_q;
    end
  end

endmodule

`default_nettype wire

@@ sv/rbd_cell.sv @@
// ----------------------------------------------------------------------------
// rbd_cell: one link of the chain
// One CORDIC vectoring step for both angles and, while STEP < RB, one square root digit.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_cell import rbd_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned STEP       = 0,
  localparam int unsigned CW   = COORD_BITS,
  localparam int unsigned XW   = CW + VEC_SHIFT + 3,
  localparam int unsigned SQW  = 2 * CW + 2,
  localparam int unsigned RB   = CW + 1,
  localparam int unsigned REMW = RB + 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  vld_i,
  input  wire logic signed [XW-1:0]  x1_i,
  input  wire logic signed [XW-1:0]  y1_i,
  input  wire logic signed [ZW-1:0]  z1_i,
  input  wire logic signed [XW-1:0]  x2_i,
  input  wire logic signed [XW-1:0]  y2_i,
  input  wire logic signed [ZW-1:0]  z2_i,
  input  wire ang_flag_t             f1_i,
  input  wire ang_flag_t             f2_i,
  input  wire logic [SQW-1:0]        v_i,
  input  wire logic [REMW-1:0]       rem_i,
  input  wire logic [RB-1:0]         root_i,
  input  wire logic [CW-1:0]         mx_i,
  input  wire logic [CW-1:0]         my_i,
  output logic                       vld_o,
  output logic signed [XW-1:0]       x1_o,
  output logic signed [XW-1:0]       y1_o,
  output logic signed [ZW-1:0]       z1_o,
  output logic signed [XW-1:0]       x2_o,
  output logic signed [XW-1:0]       y2_o,
  output logic signed [ZW-1:0]       z2_o,
  output ang_flag_t                  f1_o,
  output ang_flag_t                  f2_o,
  output logic [SQW-1:0]             v_o,
  output logic [REMW-1:0]            rem_o,
  output logic [RB-1:0]              root_o,
  output logic [CW-1:0]              mx_o,
  output logic [CW-1:0]              my_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_q16(STEP);

  logic signed [XW-1:0] x1_d, y1_d, x2_d, y2_d;
  logic signed [ZW-1:0] z1_d, z2_d;
  logic [SQW-1:0]       v_d;
  logic [REMW-1:0]      rem_d, rem_sh, trial;
  logic [RB-1:0]        root_d;

  always_comb begin
    if (y1_i > 0) begin
      x1_d = x1_i + (y1_i >>> STEP);
      y1_d = y1_i - (x1_i >>> STEP);
      z1_d = z1_i + ATAN;
    end else begin
      x1_d = x1_i - (y1_i >>> STEP);
      y1_d = y1_i + (x1_i >>> STEP);
      z1_d = z1_i - ATAN;
    end
    if (y2_i > 0) begin
      x2_d = x2_i + (y2_i >>> STEP);
      y2_d = y2_i - (x2_i >>> STEP);
      z2_d = z2_i + ATAN;
    end else begin
      x2_d = x2_i - (y2_i >>> STEP);
      y2_d = y2_i + (x2_i >>> STEP);
      z2_d = z2_i - ATAN;
    end
  end

  // restoring square root, two radicand bits per cell
  generate
    if (STEP < RB) begin : g_sqrt
      always_comb begin
        rem_sh = {rem_i[REMW-3:0], v_i[SQW-1 -: 2]};
        trial  = REMW'({root_i, 2'b01});
        v_d    = {v_i[SQW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_i[RB-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_i[RB-2:0], 1'b0};
        end
      end
    end else begin : g_pass
      always_comb begin
        rem_sh = rem_i;
        trial  = '0;
        v_d    = v_i;
        rem_d  = rem_sh | trial;
        root_d = root_i;
      end
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_o   <= x1_d;
      y1_o   <= y1_d;
      z1_o   <= z1_d;
      x2_o   <= x2_d;
      y2_o   <= y2_d;
      z2_o   <= z2_d;
      f1_o   <= f1_i;
      f2_o   <= f2_i;
      v_o    <= v_d;
      rem_o  <= rem_d;
      root_o <= root_d;
      mx_o   <= mx_i;
      my_o   <= my_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/rbd_post.sv @@
// ----------------------------------------------------------------------------
// rbd_post: output register
// Clamps and unfolds both angles, takes the difference, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_post import rbd_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned CW = COORD_BITS,
  localparam int unsigned RB = CW + 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   vld_i,
  input  wire logic signed [ZW-1:0]   z1_i,
  input  wire logic signed [ZW-1:0]   z2_i,
  input  wire ang_flag_t              f1_i,
  input  wire ang_flag_t              f2_i,
  input  wire logic [RB-1:0]          root_i,
  input  wire logic [CW-1:0]          mx_i,
  input  wire logic [CW-1:0]          my_i,
  output logic                        vld_o,
  output logic signed [TURN_W-1:0]    turn_o,
  output logic [DIST_W-1:0]           dist_o,
  output logic [MID_W-1:0]            mx_o,
  output logic [MID_W-1:0]            my_o
);

  localparam int unsigned QW = ANG_FRAC + 8;
  localparam logic signed [ZW-1:0] Q90  = ZW'(90 << ANG_FRAC);
  localparam logic [QW-1:0]        Q45U = QW'(45 << ANG_FRAC);
  localparam logic [QW-1:0]        Q90U = QW'(90 << ANG_FRAC);
  localparam logic [QW-1:0]        Q180 = QW'(180 << ANG_FRAC);

  function automatic logic signed [TURN_W-1:0] to_deg(input logic signed [ZW-1:0] z,
                                                      input ang_flag_t f);
    logic [QW-1:0]              q;
    logic [QW-1:0]              r;
    logic signed [TURN_W-1:0]   d;
    if (z < 0) begin
      q = '0;
    end else if (z > Q90) begin
      q = Q90U;
    end else begin
      q = QW'($unsigned(z));
    end
    if (f.yz) begin
      q = '0;
    end else if (f.xz) begin
      q = Q90U;
    end else if (f.eq) begin
      q = Q45U;
    end
    r = f.bneg ? Q180 - q : q;
    d = $signed(TURN_W'(r[QW-1:ANG_FRAC]));
    if (f.zero) begin
      d = '0;
    end
    return f.aneg ? -d : d;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      turn_o <= to_deg(z2_i, f2_i) - to_deg(z1_i, f1_i);
      dist_o <= DIST_W'(root_i);
      mx_o   <= MID_W'(mx_i);
      my_o   <= MID_W'(my_i);
    end
  end

endmodule

`default_nettype wire

@@ sv/robot_bearing_and_distance_unit.sv @@
// ----------------------------------------------------------------------------
// robot_bearing_and_distance_unit: heading, bearing and range of a target
// Two front stages, a chain of CORDIC / square root cells, an output register.
// ----------------------------------------------------------------------------
//  channel | signals                                          | direction
//  input   | in_valid_i, in_ready_o, front/back/target xy     | in
//  output  | out_valid_o, out_ready_i, turn_angle, distance,  | out
//          | middle_x, middle_y                               |
//
// One request enters every cycle while the output is not stalled.
// The whole pipeline advances together whenever the output register is
// empty or being read; a stalled output freezes every stage.
// Reset clears only the stage valid bits.
`default_nettype none

module robot_bearing_and_distance_unit import rbd_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [COORD_BITS-1:0]    front_x_i,
  input  wire logic [COORD_BITS-1:0]    front_y_i,
  input  wire logic [COORD_BITS-1:0]    back_x_i,
  input  wire logic [COORD_BITS-1:0]    back_y_i,
  input  wire logic [COORD_BITS-1:0]    target_x_i,
  input  wire logic [COORD_BITS-1:0]    target_y_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [TURN_W-1:0]      turn_angle_o,
  output logic [DIST_W-1:0]             distance_o,
  output logic [MID_W-1:0]              middle_x_o,
  output logic [MID_W-1:0]              middle_y_o
);

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned XW   = CW + VEC_SHIFT + 3;
  localparam int unsigned SQW  = 2 * CW + 2;
  localparam int unsigned RB   = CW + 1;
  localparam int unsigned REMW = RB + 3;
  localparam int unsigned N    = CORDIC_STEPS;

  logic en;

  logic                 vld_c  [N+1];
  logic signed [XW-1:0] x1_c   [N+1];
  logic signed [XW-1:0] y1_c   [N+1];
  logic signed [ZW-1:0] z1_c   [N+1];
  logic signed [XW-1:0] x2_c   [N+1];
  logic signed [XW-1:0] y2_c   [N+1];
  logic signed [ZW-1:0] z2_c   [N+1];
  ang_flag_t            f1_c   [N+1];
  ang_flag_t            f2_c   [N+1];
  logic [SQW-1:0]       v_c    [N+1];
  logic [REMW-1:0]      rem_c  [N+1];
  logic [RB-1:0]        root_c [N+1];
  logic [CW-1:0]        mx_c   [N+1];
  logic [CW-1:0]        my_c   [N+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  rbd_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (in_valid_i),
    .fx_i  (front_x_i),
    .fy_i  (front_y_i),
    .bx_i  (back_x_i),
    .by_i  (back_y_i),
    .tx_i  (target_x_i),
    .ty_i  (target_y_i),
    .vld_o (vld_c[0]),
    .x1_o  (x1_c[0]),
    .y1_o  (y1_c[0]),
    .x2_o  (x2_c[0]),
    .y2_o  (y2_c[0]),
    .f1_o  (f1_c[0]),
    .f2_o  (f2_c[0]),
    .sq_o  (v_c[0]),
    .mx_o  (mx_c[0]),
    .my_o  (my_c[0])
  );

  assign z1_c[0]   = '0;
  assign z2_c[0]   = '0;
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rbd_cell #(.COORD_BITS(COORD_BITS), .STEP(i)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (vld_c[i]),
      .x1_i  (x1_c[i]),
      .y1_i  (y1_c[i]),
      .z1_i  (z1_c[i]),
      .x2_i  (x2_c[i]),
      .y2_i  (y2_c[i]),
      .z2_i  (z2_c[i]),
      .f1_i  (f1_c[i]),
      .f2_i  (f2_c[i]),
      .v_i   (v_c[i]),
      .rem_i (rem_c[i]),
      .root_i(root_c[i]),
      .mx_i  (mx_c[i]),
      .my_i  (my_c[i]),
      .vld_o (vld_c[i+1]),
      .x1_o  (x1_c[i+1]),
      .y1_o  (y1_c[i+1]),
      .z1_o  (z1_c[i+1]),
      .x2_o  (x2_c[i+1]),
      .y2_o  (y2_c[i+1]),
      .z2_o  (z2_c[i+1]),
      .f1_o  (f1_c[i+1]),
      .f2_o  (f2_c[i+1]),
      .v_o   (v_c[i+1]),
      .rem_o (rem_c[i+1]),
      .root_o(root_c[i+1]),
      .mx_o  (mx_c[i+1]),
      .my_o  (my_c[i+1])
    );
  end

  rbd_post #(.COORD_BITS(COORD_BITS)) u_post (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (vld_c[N]),
    .z1_i  (z1_c[N]),
    .z2_i  (z2_c[N]),
    .f1_i  (f1_c[N]),
    .f2_i  (f2_c[N]),
    .root_i(root_c[N]),
    .mx_i  (mx_c[N]),
    .my_i  (my_c[N]),
    .vld_o (out_valid_o),
    .turn_o(turn_angle_o),
    .dist_o(distance_o),
    .mx_o  (middle_x_o),
    .my_o  (middle_y_o)
  );

  // x components never go negative in vectoring mode
  logic unused_x;
  assign unused_x = x1_c[N][XW-1] | x2_c[N][XW-1] | y1_c[N][0] | y2_c[N][0]
                    | (|rem_c[N]) | (|v_c[N]);

  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (turn_angle_o >= -360 && turn_angle_o <= 360))
    else $error("turn angle out of range");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_accept_enters_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> u_prep.vld_a_q)
    else $error("accepted request lost at first stage");

  a_chain_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(vld_c[N]))
    else $error("chain moved during stall");

endmodule

`default_nettype wire

@@ dv/robot_bearing_and_distance_unit_test.sv @@
// ----------------------------------------------------------------------------
// robot_bearing_and_distance_unit_test: self-checking bench for the unit
// Drives marker and target centers over a valid/ready request channel, predicts
// turn angle, range and robot middle with a CORDIC model, checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module robot_bearing_and_distance_unit_test import rbd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB       = COORD_BITS_DEF;
  localparam int unsigned N_RANDOM = 1930;
  localparam int unsigned MAX_CYC  = 400000;
  localparam int unsigned TAIL     = 40;

  typedef struct packed {
    logic [CB-1:0] fx, fy, bx, by, tx, ty;
  } markers_t;

  typedef struct packed {
    logic signed [TURN_W-1:0] turn;
    logic [DIST_W-1:0]        rng;
    logic [MID_W-1:0]         mx, my;
  } nav_t;

  typedef struct {
    markers_t m;
    logic     known;  // expected result typed in
    nav_t     r;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  markers_t drv = '0;
  logic in_ready_o, out_valid_o;
  logic signed [TURN_W-1:0] turn_angle_o;
  logic [DIST_W-1:0] distance_o;
  logic [MID_W-1:0] middle_x_o, middle_y_o;

  nav_t pending_nav[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle = 10;
  int unsigned recv_idle = 62;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  robot_bearing_and_distance_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .front_x_i(drv.fx), .front_y_i(drv.fy), .back_x_i(drv.bx), .back_y_i(drv.by),
    .target_x_i(drv.tx), .target_y_i(drv.ty),
    .out_valid_o, .out_ready_i, .turn_angle_o, .distance_o, .middle_x_o, .middle_y_o
  );

  localparam longint ATAN_DEG[20] = '{2949120, 1740967, 919879, 466945, 234379,
    117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // angle of (x, y), both non-negative, Q16 degrees in 0..90
  function automatic longint quad_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (y == 0) return 0;
    if (x == 0) return longint'(90) <<< 16;
    if (x == y) return longint'(45) <<< 16;
    x = x <<< 16;
    y = y <<< 16;
    for (int i = 0; i < 20; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += ATAN_DEG[i];
      end else begin
        x = x - ys; y = y + xs; z -= ATAN_DEG[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) <<< 16)) z = longint'(90) <<< 16;
    return z;
  endfunction

  // atan2(a, b) in whole degrees, truncated toward zero
  function automatic longint whole_degrees(longint a, longint b);
    longint r;
    if (a == 0 && b == 0) return 0;
    r = quad_angle(b < 0 ? -b : b, a < 0 ? -a : a);
    if (b < 0) r = (longint'(180) <<< 16) - r;
    r = (r >= 0) ? (r >>> 16) : -((-r) >>> 16);
    return (a < 0) ? -r : r;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint lo, hi, md;
    lo = 0; hi = 8192;
    while (hi - lo > 1) begin
      md = (lo + hi) / 2;
      if (md * md <= v) lo = md; else hi = md;
    end
    return lo;
  endfunction

  function automatic nav_t navigate(markers_t m);
    nav_t r;
    longint mx, my, dx, dy;
    mx = (longint'(m.fx) + m.bx) >>> 1;
    my = (longint'(m.fy) + m.by) >>> 1;
    r.turn = TURN_W'(whole_degrees(mx - m.tx, my - m.ty)
                     - whole_degrees(longint'(m.fx) - m.bx, longint'(m.fy) - m.by));
    dx = longint'(m.tx) - mx;
    dy = longint'(m.ty) - my;
    r.rng = DIST_W'(floor_sqrt(dx * dx + dy * dy));
    r.mx = MID_W'(mx);
    r.my = MID_W'(my);
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("robot_bearing_and_distance_unit_test NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, compare each accepted result
  always @(posedge clk_i) begin
    nav_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{turn_angle_o, distance_o, middle_x_o, middle_y_o};
        if (pending_nav.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_nav.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) $display("mismatch: exp %p got %p", want, got);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(markers_t m);
    drv <= m;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_nav.insert(pending_nav.size(), navigate(m));
    // random gap; valid stays high if the next request follows at once
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic logic [CB-1:0] coord();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return CB'($urandom_range(15));
      default: return CB'($urandom);
    endcase
  endfunction

  vec_t tbl[$];

  task automatic add_row(input markers_t m, input logic known, input nav_t r);
    vec_t v;
    v.m = m;
    v.known = known;
    v.r = r;
    tbl.insert(tbl.size(), v);
  endtask

  initial begin
    markers_t m;
    nav_t chk;
    // after reset, extremes, axis, diagonal and straight-back cases
    add_row('0, 1'b1, '{10'sd0, 13'd0, 12'd0, 12'd0});
    add_row('{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0}, 1'b1,
            '{10'sd45, 13'd5791, 12'd4095, 12'd4095});
    add_row('{12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095}, 1'b1,
            '{-10'sd135, 13'd5791, 12'd0, 12'd0});
    // heading straight back (+180), target ahead (0)
    add_row('{12'd100, 12'd100, 12'd100, 12'd200, 12'd100, 12'd0}, 1'b1,
            '{-10'sd180, 13'd150, 12'd100, 12'd150});
    // heading 0, target straight back: turn +180
    add_row('{12'd100, 12'd200, 12'd100, 12'd100, 12'd100, 12'd4000}, 1'b1,
            '{10'sd180, 13'd3850, 12'd100, 12'd150});
    // heading and bearing both straight back
    add_row('{12'd100, 12'd100, 12'd100, 12'd200, 12'd100, 12'd4000}, 1'b0, '0);
    add_row('{12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0}, 1'b0, '0);
    add_row('{12'd4095, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd4095}, 1'b0, '0);
    add_row('{12'd300, 12'd100, 12'd100, 12'd100, 12'd200, 12'd100}, 1'b1,
            '{-10'sd90, 13'd0, 12'd200, 12'd100});
    add_row('{12'd100, 12'd100, 12'd300, 12'd100, 12'd0, 12'd100}, 1'b0, '0);
    add_row('{12'd1, 12'd2, 12'd0, 12'd0, 12'd3, 12'd7}, 1'b0, '0);
    add_row('{12'd2047, 12'd1, 12'd2048, 12'd4094, 12'd1234, 12'd3210}, 1'b0, '0);
    add_row('{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2048, 12'd2047}, 1'b0, '0);

    // typed-in rows must agree with the predictor as well
    foreach (tbl[i]) if (tbl[i].known) begin
      chk = navigate(tbl[i].m);
      if (chk != tbl[i].r) begin
        errors++;
        if (errors <= 10) $display("table row %0d: exp %p model %p", i, tbl[i].r, chk);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tbl[i]) send(tbl[i].m);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 10 : (ph == 1) ? 62 : 0;
      recv_idle = (ph == 0) ? 62 : (ph == 1) ? 10 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        m = '{coord(), coord(), coord(), coord(), coord(), coord()};
        // near-coincident markers and targets hit axis and diagonal paths
        if ($urandom_range(9) == 0) begin
          m.bx = CB'(m.fx + CB'($urandom_range(2)) - 1);
          m.by = m.fy;
        end
        if ($urandom_range(9) == 0) m.ty = m.tx;
        send(m);
        if (ph == 0 && n == 300) begin
          // drain completely before continuing
          in_valid_i <= 1'b0;
          while (pending_nav.size() != 0) @(posedge clk_i);
        end
      end
    end
    in_valid_i <= 1'b0;
    while (pending_nav.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (errors == 0)
      $display("robot_bearing_and_distance_unit_test OK");
    else
      $display("robot_bearing_and_distance_unit_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
